// ===== rtl/core/bresenham_line_generator_unit_defines.svh =====
// Assertion macros shared by the line generator checker.
`ifndef BRESENHAM_LINE_GENERATOR_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_GENERATOR_UNIT_DEFINES_SVH

// Implication checked at every rising clock edge, muted while reset is low.
`define BLGU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define BLGU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/blgu_pkg.sv =====
// Shared types and constants of the line generator.
package blgu_pkg;

  // Coordinate width of both axes.
  localparam int unsigned COORD_BITS = 10;
  // Decision term width: holds 2*minor - 2*major and 2*minor with sign.
  localparam int unsigned DEC_BITS = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // Item kinds.
  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_e;

  // Input beat.
  typedef struct packed {
    kind_e  kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } blgu_in_t;

  // Output beat.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
    logic   idle;
  } blgu_out_t;

  // Move a coordinate one step down or up, wrapping.
  function automatic coord_t move_coord(coord_t c, logic neg);
    move_coord = neg ? coord_t'(c - coord_t'(1)) : coord_t'(c + coord_t'(1));
  endfunction

endpackage

// ===== rtl/core/blgu_in_reg.sv =====
// Input register stage of the line generator.
module blgu_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  blgu_pkg::blgu_in_t in_data_i,
  input  logic            out_free_i,
  output logic            step_en_o,
  output blgu_pkg::blgu_in_t item_o
);

  logic               valid_q, valid_d;
  blgu_pkg::blgu_in_t data_q;
  logic               in_ready;
  logic               in_fire;

  // Held beat moves on when the result register can take it.
  assign step_en_o  = valid_q & out_free_i;
  assign in_ready   = ~valid_q | step_en_o;
  assign in_stall_o = ~in_ready;
  assign in_fire    = in_valid_i & in_ready;
  assign valid_d    = in_fire | (valid_q & ~step_en_o);
  assign item_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= in_data_i;
    end
  end

endmodule

// ===== rtl/core/blgu_core.sv =====
// Line state and single-step Bresenham update.
module blgu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  blgu_pkg::blgu_in_t  item_i,
  output blgu_pkg::blgu_out_t result_o
);

  localparam int unsigned D = blgu_pkg::DEC_BITS;

  blgu_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  blgu_pkg::dec_t   dec_q, dec_d;
  blgu_pkg::coord_t steps_q, steps_d;
  blgu_pkg::coord_t maj_q, maj_d, min_q, min_d;
  logic             neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic             y_major_q, y_major_d;
  logic             busy_q, busy_d;

  blgu_pkg::coord_t dx, dy, s_maj, s_min;
  logic             s_neg_x, s_neg_y, s_y_major;
  logic             minor_step;
  logic             last, idle;

  // Setup of a new line from its endpoints.
  always_comb begin
    s_neg_x   = item_i.end_x < item_i.start_x;
    s_neg_y   = item_i.end_y < item_i.start_y;
    dx        = s_neg_x ? blgu_pkg::coord_t'(item_i.start_x - item_i.end_x)
                        : blgu_pkg::coord_t'(item_i.end_x - item_i.start_x);
    dy        = s_neg_y ? blgu_pkg::coord_t'(item_i.start_y - item_i.end_y)
                        : blgu_pkg::coord_t'(item_i.end_y - item_i.start_y);
    s_y_major = dy > dx;
    s_maj     = s_y_major ? dy : dx;
    s_min     = s_y_major ? dx : dy;
  end

  // Next state and result.
  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    dec_d      = dec_q;
    steps_d    = steps_q;
    maj_d      = maj_q;
    min_d      = min_q;
    neg_x_d    = neg_x_q;
    neg_y_d    = neg_y_q;
    y_major_d  = y_major_q;
    busy_d     = busy_q;
    last       = 1'b0;
    idle       = 1'b0;
    minor_step = ~dec_q[D-1];
    if (item_i.kind == blgu_pkg::KIND_START) begin
      cur_x_d   = item_i.start_x;
      cur_y_d   = item_i.start_y;
      neg_x_d   = s_neg_x;
      neg_y_d   = s_neg_y;
      y_major_d = s_y_major;
      maj_d     = s_maj;
      min_d     = s_min;
      steps_d   = s_maj;
      dec_d     = blgu_pkg::dec_t'({2'b00, s_min, 1'b0}) - blgu_pkg::dec_t'({3'b000, s_maj});
      busy_d    = s_maj != '0;
      last      = s_maj == '0;
    end else if (!busy_q) begin
      // Advance with no line: repeat the pixel.
      idle = 1'b1;
    end else begin
      // Major axis always moves; minor axis on a non-negative term.
      if (y_major_q) begin
        cur_y_d = blgu_pkg::move_coord(cur_y_q, neg_y_q);
        if (minor_step) begin
          cur_x_d = blgu_pkg::move_coord(cur_x_q, neg_x_q);
        end
      end else begin
        cur_x_d = blgu_pkg::move_coord(cur_x_q, neg_x_q);
        if (minor_step) begin
          cur_y_d = blgu_pkg::move_coord(cur_y_q, neg_y_q);
        end
      end
      if (minor_step) begin
        dec_d = dec_q + blgu_pkg::dec_t'({2'b00, min_q, 1'b0})
                      - blgu_pkg::dec_t'({2'b00, maj_q, 1'b0});
      end else begin
        dec_d = dec_q + blgu_pkg::dec_t'({2'b00, min_q, 1'b0});
      end
      steps_d = blgu_pkg::coord_t'(steps_q - blgu_pkg::coord_t'(1));
      last    = steps_q == blgu_pkg::coord_t'(1);
      busy_d  = ~last;
    end
  end

  assign result_o.pixel_x    = cur_x_d;
  assign result_o.pixel_y    = cur_y_d;
  assign result_o.last_pixel = last;
  assign result_o.idle       = idle;

  // Line state, updated once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      dec_q     <= '0;
      steps_q   <= '0;
      maj_q     <= '0;
      min_q     <= '0;
      neg_x_q   <= 1'b0;
      neg_y_q   <= 1'b0;
      y_major_q <= 1'b0;
      busy_q    <= 1'b0;
    end else if (step_en_i) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      dec_q     <= dec_d;
      steps_q   <= steps_d;
      maj_q     <= maj_d;
      min_q     <= min_d;
      neg_x_q   <= neg_x_d;
      neg_y_q   <= neg_y_d;
      y_major_q <= y_major_d;
      busy_q    <= busy_d;
    end
  end

endmodule

// ===== rtl/core/blgu_out_reg.sv =====
// Result register of the line generator.
module blgu_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  blgu_pkg::blgu_out_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blgu_pkg::blgu_out_t out_data_o
);

  logic                valid_q, valid_d;
  blgu_pkg::blgu_out_t data_q;

  // Takes a new result when empty or when the held beat leaves.
  assign free_o      = ~valid_q | ~out_stall_i;
  assign valid_d     = load_i | (valid_q & out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ===== rtl/core/bresenham_line_generator_unit.sv =====
// Bresenham line generator, all octants, one pixel per accepted beat.
// A start beat loads two endpoints and returns the first pixel; each advance
// beat returns the next pixel, and the final endpoint is flagged last. An
// advance with no line in progress repeats the last pixel with idle set.
// Throughput is one beat per clock while the output is not stalled, as the
// line state (cur position, decision term, step count) steps once per beat;
// a result passes the input register and then the result register.
// While a result waits stalled in the output register, the input register
// takes one more beat and then the input stalls.
module bresenham_line_generator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  blgu_pkg::blgu_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blgu_pkg::blgu_out_t out_data_o
);

  logic                out_free;
  logic                step_en;
  blgu_pkg::blgu_in_t  item;
  blgu_pkg::blgu_out_t result;

  // Input register.
  blgu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .step_en_o  (step_en),
    .item_o     (item)
  );

  // Line state and step logic.
  blgu_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (item),
    .result_o  (result)
  );

  // Result register.
  blgu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_en),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/blgu_checker.sv =====
// Port-level checks of the line generator, bound to the top level.
`include "bresenham_line_generator_unit_defines.svh"

module blgu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input blgu_pkg::blgu_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input blgu_pkg::blgu_out_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i & ~in_stall_o;

  // A stalled result holds.
  `BLGU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  // A pixel is never both last and idle.
  `BLGU_ASSERT(a_last_idle, clk_i, rst_ni, out_valid_o |-> !(out_data_o.last_pixel && out_data_o.idle), "last and idle together")
  // Input backs up only behind a stalled full output.
  `BLGU_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output stall")
  // A fresh result follows an input beat through the input and result registers.
  `BLGU_ASSERT(a_rise_src, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_beat, 2), "result without input beat")

  logic unused_in;
  assign unused_in = ^in_data_i;

endmodule

bind bresenham_line_generator_unit blgu_checker u_blgu_checker (.*);
